[rtl/mk_firm_window_monitor_unit_assert.svh]
// Assertion macros for the (m,k)-firm window monitor.
`ifndef MK_FIRM_WINDOW_MONITOR_UNIT_ASSERT_SVH
`define MK_FIRM_WINDOW_MONITOR_UNIT_ASSERT_SVH

// ante implies cons in the same cycle
`define MKFWM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the next cycle
`define MKFWM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mkfwm_pkg.sv]
// Shared types and constants of the (m,k)-firm window monitor.
`default_nettype none
package mkfwm_pkg;

	localparam int K_W       = 6;
	localparam int WIN_W     = 63;
	localparam int RED_W     = 62;
	localparam int CNT_W     = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_MET    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_WIN   = 2'd2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// common control broadcast to every window cell
	typedef struct packed {
		logic           clear;
		logic           shift;
		logic [K_W-1:0] k;
	} mkfwm_ctl_t;

	typedef struct packed {
		logic             violated_now;
		logic [CNT_W-1:0] violation_count;
		logic [K_W-1:0]   current_sum;
		logic             state_valid;
		logic [WIN_W-1:0] window_bits;
		logic [RED_W-1:0] reduced_bits;
	} mkfwm_res_t;

endpackage
`default_nettype wire

[rtl/mkfwm_cell.sv]
// One slot of the outcome window: holds a bit and passes it to the next slot on a shift.
`default_nettype none
module mkfwm_cell #(
	parameter int IDX = 0
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mkfwm_pkg::mkfwm_ctl_t  ctl,
	input  wire logic                   prev,
	output logic                        q,
	output logic                        last_tap,
	output logic                        nxt,
	output logic                        nxt_red
);
	import mkfwm_pkg::*;

	localparam logic [K_W:0] POS  = (K_W+1)'(IDX);
	localparam logic [K_W:0] POS1 = (K_W+1)'(IDX + 1);

	logic bit_q;
	logic in_win;
	logic in_red;
	logic is_last;

	assign in_win  = POS < {1'b0, ctl.k};
	assign in_red  = POS1 < {1'b0, ctl.k};
	assign is_last = POS1 == {1'b0, ctl.k};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctl.clear) begin
			bit_q <= 1'b0;
		end else if (ctl.shift) begin
			bit_q <= nxt;
		end
	end

	assign q        = bit_q;
	assign last_tap = bit_q & is_last;
	assign nxt      = prev & in_win;
	assign nxt_red  = prev & in_red;

endmodule
`default_nettype wire

[rtl/mk_firm_window_monitor_unit.sv]
// (m,k)-firm deadline monitor: sliding window of job outcomes with violation counting.
`default_nettype none
`include "mk_firm_window_monitor_unit_assert.svh"
// Takes one job outcome per cycle while in_stall is low and returns one result per
// outcome through a registered output; the window is a chain of MAX_WINDOW one-bit
// cells that all shift together, with the running sums kept beside it and updated on
// the same push. Results sit in an output register backed by a skid register, so a
// stalled consumer stalls the input only once both are full. Writing window_len or
// initial_window reloads the window: the preload is shifted into the cell chain one
// bit per cycle, k bits in all (k the effective window length), and in_stall stays
// high while it loads. Writing min_met takes effect at once.
module mk_firm_window_monitor_unit #(
	parameter int MAX_WINDOW = 63
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [mkfwm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mkfwm_pkg::WIN_W-1:0]        cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               job_met,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    violated_now,
	output logic [mkfwm_pkg::CNT_W-1:0]             violation_count,
	output logic [mkfwm_pkg::K_W-1:0]               current_sum,
	output logic                                    state_valid,
	output logic [mkfwm_pkg::WIN_W-1:0]             window_bits,
	output logic [mkfwm_pkg::RED_W-1:0]             reduced_bits
);
	import mkfwm_pkg::*;

	localparam logic [K_W-1:0] MAX_K = K_W'(MAX_WINDOW);

	// configuration registers
	logic [K_W-1:0]   min_met_q;
	logic [K_W-1:0]   window_len_q;
	logic [WIN_W-1:0] init_q;

	// monitor state
	logic [K_W-1:0]   sum_q;
	logic [K_W-1:0]   pushed_q;
	logic [K_W-1:0]   rec_q;
	logic [CNT_W-1:0] viol_q;
	logic             loading_q;
	logic [K_W-1:0]   load_cnt_q;

	// result registers
	logic             out_valid_q;
	mkfwm_res_t       out_q;
	logic             skid_valid_q;
	mkfwm_res_t       skid_q;

	logic [K_W-1:0]   k_eff;
	logic             reload_wr;
	logic             acc;
	logic             out_take;
	logic             shift_in;
	logic             load_done;
	mkfwm_ctl_t       ctl;

	logic [MAX_WINDOW-1:0] cell_q;
	logic [MAX_WINDOW-1:0] cell_tap;
	logic [MAX_WINDOW-1:0] cell_nxt;
	logic [MAX_WINDOW-1:0] cell_red;
	logic                  oldest;

	logic [K_W-1:0]   sum_n;
	logic             rec_lt;
	logic [K_W-1:0]   pushed_n;
	logic [K_W-1:0]   rec_n;
	logic             full;
	logic             viol_now;
	logic [CNT_W-1:0] viol_n;
	logic [K_W-1:0]   cur;
	mkfwm_res_t       res;

	always_comb begin
		if (window_len_q == '0) begin
			k_eff = K_W'(1);
		end else if (window_len_q > MAX_K) begin
			k_eff = MAX_K;
		end else begin
			k_eff = window_len_q;
		end
	end

	assign reload_wr = cfg_we && (cfg_index == REG_WINDOW_LEN || cfg_index == REG_INIT_WIN);
	assign in_stall  = loading_q | skid_valid_q;
	assign acc       = in_valid & ~in_stall;
	assign out_take  = out_valid_q & ~out_stall;
	assign shift_in  = loading_q ? init_q[load_cnt_q] : job_met;
	assign load_done = K_W'(load_cnt_q + K_W'(1)) == k_eff;

	always_comb begin
		ctl.clear = reload_wr;
		ctl.shift = ~reload_wr & (loading_q | acc);
		ctl.k     = k_eff;
	end

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic prev;
		if (i == 0) begin : g_head
			assign prev = shift_in;
		end else begin : g_link
			assign prev = cell_q[i-1];
		end
		mkfwm_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.prev     (prev),
			.q        (cell_q[i]),
			.last_tap (cell_tap[i]),
			.nxt      (cell_nxt[i]),
			.nxt_red  (cell_red[i])
		);
	end

	assign oldest = |cell_tap;

	always_comb begin
		sum_n    = sum_q - K_W'(oldest) + K_W'(shift_in);
		rec_lt   = rec_q < k_eff;
		pushed_n = rec_lt ? K_W'(pushed_q + K_W'(job_met)) : pushed_q;
		rec_n    = rec_lt ? K_W'(rec_q + K_W'(1)) : rec_q;
		full     = rec_n >= k_eff;
		viol_now = full && (sum_n < min_met_q);
		viol_n   = (viol_now && viol_q != CNT_MAX) ? CNT_W'(viol_q + CNT_W'(1)) : viol_q;
		cur      = full ? sum_n : K_W'(pushed_n + K_W'(k_eff - rec_n));

		res.violated_now    = viol_now;
		res.violation_count = viol_n;
		res.current_sum     = cur;
		res.state_valid     = cur >= min_met_q;
		res.window_bits     = WIN_W'(cell_nxt);
		res.reduced_bits    = RED_W'(cell_red);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_met_q    <= K_W'(1);
			window_len_q <= K_W'(1);
			init_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_MET:    min_met_q    <= cfg_data[K_W-1:0];
				REG_WINDOW_LEN: window_len_q <= cfg_data[K_W-1:0];
				REG_INIT_WIN:   init_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			pushed_q   <= '0;
			rec_q      <= '0;
			viol_q     <= '0;
			loading_q  <= 1'b0;
			load_cnt_q <= '0;
		end else if (reload_wr) begin
			// clear and refill the window from the preload
			sum_q      <= '0;
			pushed_q   <= '0;
			rec_q      <= '0;
			viol_q     <= '0;
			loading_q  <= 1'b1;
			load_cnt_q <= '0;
		end else if (loading_q) begin
			sum_q      <= sum_n;
			load_cnt_q <= K_W'(load_cnt_q + K_W'(1));
			if (load_done) begin
				loading_q <= 1'b0;
			end
		end else if (acc) begin
			sum_q    <= sum_n;
			pushed_q <= pushed_n;
			rec_q    <= rec_n;
			viol_q   <= viol_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= acc;
			end
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (acc) begin
				out_q <= res;
			end
		end else if (acc) begin
			skid_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign violated_now    = out_q.violated_now;
	assign violation_count = out_q.violation_count;
	assign current_sum     = out_q.current_sum;
	assign state_valid     = out_q.state_valid;
	assign window_bits     = out_q.window_bits;
	assign reduced_bits    = out_q.reduced_bits;

	`MKFWM_ASSERT_SAME(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full while output empty")
	`MKFWM_ASSERT_SAME(a_rec_bound, !loading_q, rec_q <= k_eff, "recorded count above window length")
	`MKFWM_ASSERT_SAME(a_sum_bound, 1'b1, sum_q <= k_eff, "window sum above window length")
	`MKFWM_ASSERT_NEXT(a_count_step, acc && !reload_wr, (viol_q == $past(viol_q)) || (viol_q == CNT_W'($past(viol_q) + CNT_W'(1))), "violation count moved by more than one")

endmodule
`default_nettype wire
